[src/cao_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cao_pkg
// shared types, widths and helpers for the cursor alpha overlay block
// ----------------------------------------------------------------------------
package cao_pkg;

	localparam int CURSOR_MAX_DIM_DEF = 64;
	localparam int WINDOW_MAX_DIM_DEF = 4096;

	localparam int PIX_W      = 32;
	localparam int COORD_W    = 12;
	localparam int POS_W      = 14;
	localparam int DIM_W      = 7;
	localparam int OFS_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int PROD_W     = 16;

	localparam logic [7:0] ALPHA_MAX    = 8'd255;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [7:0] ROUND_HALF   = 8'd127;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_BLEND = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_POS_X  = 3'd0,
		REG_WINDOW_POS_Y  = 3'd1,
		REG_CURSOR_POS_X  = 3'd2,
		REG_CURSOR_POS_Y  = 3'd3,
		REG_CURSOR_WIDTH  = 3'd4,
		REG_CURSOR_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEL_WINDOW = 2'd0,
		SEL_CURSOR = 2'd1,
		SEL_BLEND  = 2'd2
	} sel_t;

	// first stage: item with its cursor-space coordinates
	typedef struct packed {
		mode_t                   mode;
		logic                    in_win;
		logic [PIX_W-1:0]        pixel;
		logic signed [OFS_W-1:0] cx;
		logic signed [OFS_W-1:0] cy;
	} coord_s1_t;

	// exact p/255 for p below 65280
	function automatic logic [7:0] div255(input logic [PROD_W-1:0] p);
		logic [PROD_W:0] t;
		t = (PROD_W+1)'(p) + (PROD_W+1)'(p[PROD_W-1:8]) + (PROD_W+1)'(1);
		return t[PROD_W-1:8];
	endfunction

endpackage

[src/cao_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cao_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cao_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/cao_coord.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cao_coord
// first stage: window to cursor coordinate translation
// ----------------------------------------------------------------------------
module cao_coord import cao_pkg::*; #(
	parameter int WINDOW_MAX_DIM = WINDOW_MAX_DIM_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic                    mode,
	input  logic [PIX_W-1:0]        pixel_in,
	input  logic [COORD_W-1:0]      coord_x,
	input  logic [COORD_W-1:0]      coord_y,
	input  logic signed [POS_W-1:0] window_pos_x,
	input  logic signed [POS_W-1:0] window_pos_y,
	input  logic signed [POS_W-1:0] cursor_pos_x,
	input  logic signed [POS_W-1:0] cursor_pos_y,
	output coord_s1_t               item_s1
);

	localparam int WinW = $clog2(WINDOW_MAX_DIM + 1);
	localparam int CmpW = (WinW > COORD_W) ? WinW : COORD_W;

	logic signed [OFS_W-1:0] x_ext, y_ext, tx, ty;
	logic                    is_blend;
	logic                    in_win;

	assign is_blend = (mode == MODE_BLEND);
	assign x_ext    = signed'({{(OFS_W-COORD_W){1'b0}}, coord_x});
	assign y_ext    = signed'({{(OFS_W-COORD_W){1'b0}}, coord_y});
	assign tx       = x_ext + OFS_W'(window_pos_x) - OFS_W'(cursor_pos_x);
	assign ty       = y_ext + OFS_W'(window_pos_y) - OFS_W'(cursor_pos_y);
	assign in_win   = (CmpW'(coord_x) < CmpW'(WINDOW_MAX_DIM))
	               && (CmpW'(coord_y) < CmpW'(WINDOW_MAX_DIM));

	// loads keep their raw cursor coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.mode   <= mode_t'(mode);
			item_s1.in_win <= is_blend ? in_win : 1'b1;
			item_s1.pixel  <= pixel_in;
			item_s1.cx     <= is_blend ? tx : x_ext;
			item_s1.cy     <= is_blend ? ty : y_ext;
		end
	end

endmodule

[src/cao_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cao_blend
// two stage premultiplied over blend: scale window channels, then /255 and add
// ----------------------------------------------------------------------------
module cao_blend import cao_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             hit,
	input  logic [PIX_W-1:0] win_pix,
	input  logic [PIX_W-1:0] cur_pix,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pixel_out
);

	logic              v_s3, v_s4;
	logic              en_s3, en_s4;
	sel_t              sel_s3;
	logic [PIX_W-1:0]  w_s3, c_s3, pix_s4;
	logic [PROD_W-1:0] prod_s3 [3];

	logic [7:0]        alpha, inv_alpha;
	sel_t              sel;
	logic [PIX_W-1:0]  mix;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	assign alpha     = cur_pix[31:24];
	assign inv_alpha = ALPHA_MAX - alpha;

	always_comb begin
		if (!hit || alpha == 8'd0) begin
			sel = SEL_WINDOW;
		end else if (alpha == ALPHA_MAX) begin
			sel = SEL_CURSOR;
		end else begin
			sel = SEL_BLEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 3: per-channel w*(255-a) with rounding bias
	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			sel_s3 <= sel;
			w_s3   <= win_pix;
			c_s3   <= cur_pix;
			for (int ch = 0; ch < 3; ch++) begin
				prod_s3[ch] <= PROD_W'(win_pix[8*ch +: 8]) * PROD_W'(inv_alpha)
				             + PROD_W'(ROUND_HALF);
			end
		end
	end

	always_comb begin
		mix[31:24] = ALPHA_OPAQUE;
		for (int ch = 0; ch < 3; ch++) begin
			mix[8*ch +: 8] = c_s3[8*ch +: 8] + div255(prod_s3[ch]);
		end
	end

	// stage 4: output register
	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			case (sel_s3)
				SEL_WINDOW: pix_s4 <= w_s3;
				SEL_CURSOR: pix_s4 <= c_s3;
				SEL_BLEND:  pix_s4 <= mix;
				default:    pix_s4 <= w_s3;
			endcase
		end
	end

	assign out_valid = v_s4;
	assign pixel_out = pix_s4;

	a_blend_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en_s4 && sel_s3 == SEL_BLEND) |=> (pix_s4[31:24] == ALPHA_OPAQUE))
		else $error("blended pixel lost opaque alpha");

	a_window_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en_s4 && sel_s3 == SEL_WINDOW) |=> (pix_s4 == $past(w_s3)))
		else $error("pass-through pixel altered");

	a_take_fills_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s3)
		else $error("accepted beat missing from stage 3");

endmodule

[src/cursor_alpha_overlay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_alpha_overlay
// premultiplied alpha cursor overlay on a stream of window pixels
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready) carries mode, pixel_in, coord_x, coord_y.
//   a load beat (mode 0) writes pixel_in into the cursor store at cursor
//   column coord_x, row coord_y and gives no result. a blend beat (mode 1)
//   gives one pixel_out beat on the out channel (out_valid/out_ready).
//   cfg channel (cfg_valid/cfg_ready, always ready) writes the window and
//   cursor positions and the cursor size; write it only while no beat is
//   in flight.
//   a blend beat passes the coordinate stage, store read stage, multiply stage
//   and the /255 + add stage that is also the output register, in that order.
//   throughput is one beat per cycle while out_ready stays high: every
//   stage takes a new beat each cycle and each beat makes at most one
//   store access in stage 2.
//   reset clears the config registers to zero and empties the pipe; the cursor
//   store is not cleared, entries must be loaded before they are shown.
//   when out_ready is low each stage holds its beat, bubbles still close
//   up, and in_ready drops only once all four stages are full.
// ----------------------------------------------------------------------------
module cursor_alpha_overlay import cao_pkg::*; #(
	parameter int CURSOR_MAX_DIM = CURSOR_MAX_DIM_DEF,
	parameter int WINDOW_MAX_DIM = WINDOW_MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic [COORD_W-1:0]    coord_x,
	input  logic [COORD_W-1:0]    coord_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CurW  = $clog2(CURSOR_MAX_DIM);
	localparam int AddrW = 2 * CurW;
	localparam int Depth = 2 ** AddrW;
	localparam int LimB  = $clog2(CURSOR_MAX_DIM + 1);
	localparam int LimW  = (LimB > DIM_W) ? LimB : DIM_W;

	// configuration registers
	logic signed [POS_W-1:0] win_x_q, win_y_q, cur_x_q, cur_y_q;
	logic [DIM_W-1:0]        cur_w_q, cur_h_q;

	// pipeline control
	logic                    v_s1, v_s2;
	logic                    en_s1, en_s2;
	coord_s1_t               item_s1;
	logic                    hit_s2;
	logic [PIX_W-1:0]        pix_s2;
	logic                    blend_ready;

	// stage 2 decode
	logic [LimW-1:0]         lim_w, lim_h, lim_x, lim_y;
	logic                    is_load_s1, hit;
	logic                    ram_we, ram_re;
	logic [AddrW-1:0]        ram_addr;
	logic [PIX_W-1:0]        cur_pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_q <= '0;
			win_y_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			cur_w_q <= '0;
			cur_h_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_POS_X:  win_x_q <= signed'(cfg_data[POS_W-1:0]);
				REG_WINDOW_POS_Y:  win_y_q <= signed'(cfg_data[POS_W-1:0]);
				REG_CURSOR_POS_X:  cur_x_q <= signed'(cfg_data[POS_W-1:0]);
				REG_CURSOR_POS_Y:  cur_y_q <= signed'(cfg_data[POS_W-1:0]);
				REG_CURSOR_WIDTH:  cur_w_q <= cfg_data[DIM_W-1:0];
				REG_CURSOR_HEIGHT: cur_h_q <= cfg_data[DIM_W-1:0];
				default:           ;  // unknown index, dropped
			endcase
		end
	end

	// each stage advances when it is empty or its successor moves
	assign en_s2    = !v_s2 || blend_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				// loads retire here, only blends go on
				v_s2 <= v_s1 && !is_load_s1;
			end
		end
	end

	// stage 1: cursor-space coordinates
	cao_coord #(
		.WINDOW_MAX_DIM (WINDOW_MAX_DIM)
	) u_coord (
		.clk          (clk),
		.en           (en_s1 && in_valid),
		.mode         (mode),
		.pixel_in     (pixel_in),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.window_pos_x (win_x_q),
		.window_pos_y (win_y_q),
		.cursor_pos_x (cur_x_q),
		.cursor_pos_y (cur_y_q),
		.item_s1      (item_s1)
	);

	// stage 2: rectangle test and store access
	// cursor size saturates at the store dimension
	assign lim_w = (LimW'(cur_w_q) > LimW'(CURSOR_MAX_DIM)) ? LimW'(CURSOR_MAX_DIM)
	                                                        : LimW'(cur_w_q);
	assign lim_h = (LimW'(cur_h_q) > LimW'(CURSOR_MAX_DIM)) ? LimW'(CURSOR_MAX_DIM)
	                                                        : LimW'(cur_h_q);
	assign is_load_s1 = (item_s1.mode == MODE_LOAD);
	assign lim_x      = is_load_s1 ? LimW'(CURSOR_MAX_DIM) : lim_w;
	assign lim_y      = is_load_s1 ? LimW'(CURSOR_MAX_DIM) : lim_h;

	assign hit = item_s1.in_win
	          && !item_s1.cx[OFS_W-1] && !item_s1.cy[OFS_W-1]
	          && (item_s1.cx < signed'(OFS_W'(lim_x)))
	          && (item_s1.cy < signed'(OFS_W'(lim_y)));

	// loads and blends take the store at the same stage, so a blend right
	// after a load of the same entry reads the new value
	assign ram_addr = {item_s1.cy[CurW-1:0], item_s1.cx[CurW-1:0]};
	assign ram_we   = en_s2 && v_s1 && is_load_s1 && hit;
	assign ram_re   = en_s2 && v_s1 && !is_load_s1 && hit;

	cao_ram #(
		.WIDTH (PIX_W),
		.DEPTH (Depth)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_addr),
		.wr_data (item_s1.pixel),
		.rd_en   (ram_re),
		.rd_addr (ram_addr),
		.rd_data (cur_pix)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			hit_s2 <= hit;
			pix_s2 <= item_s1.pixel;
		end
	end

	// stages 3 and 4
	cao_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (blend_ready),
		.hit       (hit_s2),
		.win_pix   (pix_s2),
		.cur_pix   (cur_pix),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out)
	);

	a_store_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read in one cycle");

	a_load_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && is_load_s1 && en_s2) |=> !v_s2)
		else $error("load beat leaked past the store stage");

	a_off_window_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en_s2 && !item_s1.in_win) |=> !hit_s2)
		else $error("pixel beyond the window hit the cursor");

endmodule

[dv/cursor_overlay_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_overlay_checker
// watches the config, pixel and result channels of the cursor overlay block,
// keeps its own register file and cursor store, predicts pixel_out for every
// blend beat and compares results in order
// ----------------------------------------------------------------------------
module cursor_overlay_checker import cao_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  mode,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic [COORD_W-1:0]    coord_x,
	input  logic [COORD_W-1:0]    coord_y,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [PIX_W-1:0]      pixel_out,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending,
	output int                    errors
);

	localparam int CDIM = CURSOR_MAX_DIM_DEF;

	logic signed [POS_W-1:0] win_x, win_y, cur_x, cur_y;
	logic [DIM_W-1:0]        cur_w, cur_h;
	logic [PIX_W-1:0]        cursor_store [CDIM*CDIM];
	logic [PIX_W-1:0]        expected_pixels [$];

	function automatic logic [PIX_W-1:0] predict_overlay(input logic [PIX_W-1:0] w,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int col, row, lim_w, lim_h, a, sum;
		logic [PIX_W-1:0] c, res;
		if (x >= WINDOW_MAX_DIM_DEF || y >= WINDOW_MAX_DIM_DEF)
			return w;
		col = int'(x) + int'(win_x) - int'(cur_x);
		row = int'(y) + int'(win_y) - int'(cur_y);
		lim_w = (int'(cur_w) > CDIM) ? CDIM : int'(cur_w);
		lim_h = (int'(cur_h) > CDIM) ? CDIM : int'(cur_h);
		if (col < 0 || row < 0 || col >= lim_w || row >= lim_h)
			return w;
		c = cursor_store[row*CDIM + col];
		a = int'(c[31:24]);
		if (a == 0)
			return w;
		if (a == int'(ALPHA_MAX))
			return c;
		res = {ALPHA_OPAQUE, 24'd0};
		for (int k = 0; k < 3; k++) begin
			sum = int'(c[8*k +: 8]) +
				(int'(w[8*k +: 8]) * (int'(ALPHA_MAX) - a) + int'(ROUND_HALF)) / int'(ALPHA_MAX);
			res[8*k +: 8] = 8'(sum);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [PIX_W-1:0] want;
		if (!arst_n) begin
			win_x = '0;
			win_y = '0;
			cur_x = '0;
			cur_y = '0;
			cur_w = '0;
			cur_h = '0;
			expected_pixels.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			// results first, so a beat can never match an expectation pushed at the same edge
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel_out beat %h with no blend beat waiting", pixel_out);
					errors <= errors + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out !== want) begin
						$error("pixel_out mismatch: expected %h, got %h", want, pixel_out);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_POS_X:  win_x = cfg_data;
					REG_WINDOW_POS_Y:  win_y = cfg_data;
					REG_CURSOR_POS_X:  cur_x = cfg_data;
					REG_CURSOR_POS_Y:  cur_y = cfg_data;
					REG_CURSOR_WIDTH:  cur_w = cfg_data[DIM_W-1:0];
					REG_CURSOR_HEIGHT: cur_h = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (mode_t'(mode) == MODE_LOAD) begin
					if (coord_x < CDIM && coord_y < CDIM)
						cursor_store[int'(coord_y)*CDIM + int'(coord_x)] = pixel_in;
				end else begin
					expected_pixels.push_back(predict_overlay(pixel_in, coord_x, coord_y));
				end
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives cursor loads and window pixels through cursor_alpha_overlay under
// a series of window/cursor placements, with random gaps on both sides and a
// long output stall; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
	import cao_pkg::*;

	localparam int CDIM            = CURSOR_MAX_DIM_DEF;
	localparam int COORD_MAX       = WINDOW_MAX_DIM_DEF - 1;
	localparam int N_PHASES        = 10;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int LONG_STALL      = 300;
	// pipe is four deep, the drain waits this long for it to settle
	localparam int SETTLE_CYCLES   = 8;
	localparam int LIMIT_NS        = 4_000_000;

	// indexes past the last register, the block must ignore them
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  mode = 1'b0;
	logic [PIX_W-1:0]      pixel_in = '0;
	logic [COORD_W-1:0]    coord_x = '0;
	logic [COORD_W-1:0]    coord_y = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PIX_W-1:0]      pixel_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int pending;
	int fail_count;

	// stimulus-side copy of the placement, used only to aim pixels at the cursor
	int win_x, win_y, cur_x, cur_y, cur_w, cur_h;
	bit loaded [CDIM*CDIM];

	// idle rates in percent, and the one-shot long output stall
	int send_idle_pct = 25;
	int recv_idle_pct = 86;
	logic long_stall_req = 1'b0;
	bit stall_taken = 1'b0;
	int stall_left = 0;

	int n_loads, n_ignored, n_blends, n_hits;

	cursor_alpha_overlay DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.pixel_in  (pixel_in),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cursor_overlay_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.pixel_in  (pixel_in),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (fail_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: random backpressure, plus one long hold-off counted here
	always @(posedge clk) begin
		if (long_stall_req && !stall_taken) begin
			stall_taken <= 1'b1;
			stall_left <= LONG_STALL;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// hard stop in case the block hangs or drops a result
	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d results still pending", pending);
		$display("cursor_alpha_overlay verification failed");
		$finish;
	end

	// sizes above the store dimension saturate
	function automatic int dim_limit(input int v);
		return (v > CDIM) ? CDIM : v;
	endfunction

	// does a window pixel land on the cursor, and where
	function automatic bit in_cursor(input int x, input int y, output int col, output int row);
		col = x + win_x - cur_x;
		row = y + win_y - cur_y;
		return col >= 0 && row >= 0 && col < dim_limit(cur_w) && row < dim_limit(cur_h);
	endfunction

	function automatic int to_pos(input int v);
		return (v > 8191) ? 8191 : ((v < -8192) ? -8192 : v);
	endfunction

	// cursor pixels: plenty of fully clear and fully opaque ones
	function automatic logic [PIX_W-1:0] rand_cursor_pixel();
		logic [7:0] a;
		case ($urandom_range(4))
			0: a = 8'h00;
			1: a = ALPHA_MAX;
			default: a = 8'($urandom);
		endcase
		return {a, 24'($urandom)};
	endfunction

	function automatic logic [PIX_W-1:0] rand_window_pixel();
		case ($urandom_range(9))
			0: return '1;
			1: return '0;
			default: return $urandom;
		endcase
	endfunction

	// one beat on the pixel channel; valid stays up between back-to-back beats
	task automatic send_beat(input mode_t m, input logic [PIX_W-1:0] p, input int x, input int y);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		pixel_in <= p;
		coord_x <= COORD_W'(x);
		coord_y <= COORD_W'(y);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_beat(input int x, input int y, input logic [PIX_W-1:0] p);
		send_beat(MODE_LOAD, p, x, y);
		n_loads++;
		if (x < CDIM && y < CDIM)
			loaded[y*CDIM + x] = 1'b1;
		else
			n_ignored++;
	endtask

	// a pixel that lands on a never-loaded cursor entry gets that entry loaded first
	task automatic blend_beat(input int x, input int y, input logic [PIX_W-1:0] w);
		int col, row;
		bit hit;
		hit = in_cursor(x, y, col, row);
		if (hit && !loaded[row*CDIM + col])
			load_beat(col, row, rand_cursor_pixel());
		send_beat(MODE_BLEND, w, x, y);
		n_blends++;
		if (hit)
			n_hits++;
	endtask

	// stop sending, let every result come back, then let any trailing load retire
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// size registers take 7 bits, so junk goes into the upper data bits
	task automatic set_config(input int wx, input int wy, input int cx, input int cy,
			input int w, input int h);
		drain();
		win_x = wx;
		win_y = wy;
		cur_x = cx;
		cur_y = cy;
		cur_w = w;
		cur_h = h;
		cfg_write(REG_WINDOW_POS_X, CFG_DATA_W'(wx));
		cfg_write(REG_WINDOW_POS_Y, CFG_DATA_W'(wy));
		cfg_write(REG_CURSOR_POS_X, CFG_DATA_W'(cx));
		cfg_write(REG_CURSOR_POS_Y, CFG_DATA_W'(cy));
		cfg_write(REG_CURSOR_WIDTH, {DIM_W'($urandom), DIM_W'(w)});
		cfg_write(REG_CURSOR_HEIGHT, {DIM_W'($urandom), DIM_W'(h)});
	endtask

	initial begin
		int r, x, y, col, row, wx, cx, wy, cy;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cursor at the window origin, full size
		set_config(0, 0, 0, 0, CDIM, CDIM);
		load_beat(0, 0, 32'h0012_3456);                   // clear cursor keeps window
		blend_beat(0, 0, 32'hffff_ffff);
		load_beat(CDIM-1, CDIM-1, 32'hff00_0000);         // opaque cursor, far corner
		blend_beat(CDIM-1, CDIM-1, 32'h1234_5678);
		load_beat(1, 0, 32'h80ff_ffff);                   // channel sum wraps
		blend_beat(1, 0, 32'hffff_ffff);
		load_beat(2, 0, 32'h0100_0000);                   // faintest alpha
		blend_beat(2, 0, 32'hffff_ffff);
		load_beat(3, 0, 32'hfe7f_0080);                   // nearly opaque
		blend_beat(3, 0, 32'h00ff_ff00);
		load_beat(0, 1, 32'h4010_2030);
		// loads past the store edge must not alias onto real entries
		load_beat(CDIM, 0, 32'hffab_cdef);
		load_beat(0, CDIM, 32'hffab_cdef);
		load_beat(COORD_MAX, COORD_MAX, 32'hffff_ffff);
		blend_beat(0, 1, 32'h5555_aaaa);
		blend_beat(0, 0, 32'hdead_beef);
		// window pixels just off the cursor and at the window's far edge
		blend_beat(CDIM, 0, 32'h0bad_cafe);
		blend_beat(0, CDIM, 32'h0bad_cafe);
		blend_beat(COORD_MAX, COORD_MAX, 32'h0000_0000);
		load_beat(0, 0, 32'h7f80_8080);
		blend_beat(0, 0, 32'h0000_0000);
		// writes to indexes past the register file change nothing
		drain();
		cfg_write(REG_UNUSED_LO, 14'h3fff);
		cfg_write(REG_UNUSED_HI, 14'h2aaa);
		blend_beat(1, 0, 32'h0000_0000);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// idle pattern: slow receiver, then slow sender, then full rate
			if (ph < 4) begin
				send_idle_pct = 25;
				recv_idle_pct <= 86;
			end else if (ph < 7) begin
				send_idle_pct = 86;
				recv_idle_pct <= 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			case (ph)
				0: set_config(0, 0, 100, 50, CDIM, CDIM);
				1: set_config(-8192, -8192, -7192, -6192, 16, 8);
				2: set_config(8191, 8191, 8191, 8191, 127, 100);   // sizes saturate
				3: set_config(0, 0, 0, 0, 0, 5);                   // zero width disables
				4: set_config(300, -20, 310, -10, 1, 1);           // single cursor pixel
				5: set_config(-8192, 8191, 8191, -8192, CDIM, CDIM); // cursor unreachable
				default: begin
					wx = int'($urandom_range(16383)) - 8192;
					wy = int'($urandom_range(16383)) - 8192;
					cx = to_pos(wx + int'($urandom_range(4160)) - 64);
					cy = to_pos(wy + int'($urandom_range(4160)) - 64);
					if ($urandom_range(3) == 0)
						set_config(wx, wy, cx, cy, $urandom_range(127), $urandom_range(127));
					else
						set_config(wx, wy, cx, cy, $urandom_range(1, 12), $urandom_range(1, 12));
				end
			endcase

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// full-rate phase: hold the output long enough to back up the pipe
				if (ph == 8 && i == 10)
					long_stall_req <= 1'b1;
				// pause mid-phase until everything has come back
				if (ph == 5 && i == ITEMS_PER_PHASE/2)
					drain();
				r = $urandom_range(99);
				if (r < 15) begin
					if ($urandom_range(4) == 0)
						load_beat($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
							rand_cursor_pixel());
					else
						load_beat($urandom_range(CDIM-1), $urandom_range(CDIM-1),
							rand_cursor_pixel());
				end else if (r < 75) begin
					// aim at the cursor rectangle and a two-pixel margin around it
					col = int'($urandom_range(dim_limit(cur_w) + 3)) - 2;
					row = int'($urandom_range(dim_limit(cur_h) + 3)) - 2;
					x = col + cur_x - win_x;
					y = row + cur_y - win_y;
					if (x < 0 || x > COORD_MAX)
						x = $urandom_range(COORD_MAX);
					if (y < 0 || y > COORD_MAX)
						y = $urandom_range(COORD_MAX);
					blend_beat(x, y, rand_window_pixel());
				end else begin
					if ($urandom_range(9) == 0) begin
						x = $urandom_range(1) * COORD_MAX;
						y = $urandom_range(1) * COORD_MAX;
					end else begin
						x = $urandom_range(COORD_MAX);
						y = $urandom_range(COORD_MAX);
					end
					blend_beat(x, y, rand_window_pixel());
				end
			end
		end

		drain();
		$display("%0d cursor loads (%0d outside the store), %0d window pixels, %0d on the cursor,",
			n_loads, n_ignored, n_blends, n_hits);
		$display("over %0d cursor placements with both sides stalling", N_PHASES + 1);
		if (fail_count == 0)
			$display("cursor_alpha_overlay verification clean");
		else
			$display("cursor_alpha_overlay verification failed");
		$finish;
	end

endmodule
